@@ hdl/fcct_pkg.sv @@
// Shared types and constants for the frustum corner cull test unit.
// Used by fcct_cell, frustum_corner_cull_test_unit and fcct_checker; depends on nothing.
package fcct_pkg;

   localparam int COORD_W        = 16;   // Q12.4 corner coordinate
   localparam int PLANE_W        = 64;   // packed plane register
   localparam int NUM_PLANE_REGS = 6;    // planes that have a register
   localparam int NUM_PLANES_DEF = 6;
   localparam int CSR_INDEX_W    = 3;
   localparam int PROD_W         = 32;   // Q1.14 * Q12.4 product
   localparam int DIST_W         = 34;   // sum of three products and the offset
   localparam int OFFSET_SHIFT   = 14;   // aligns the Q12.4 offset to 18 fraction bits
   localparam int REQ_DATA_W     = 48;
   localparam int RSP_DATA_W     = 8;

   // One corner as it travels down the row of plane cells.
   typedef struct packed {
      logic                       valid;
      logic                       last;
      logic signed [COORD_W-1:0]  x;
      logic signed [COORD_W-1:0]  y;
      logic signed [COORD_W-1:0]  z;
      logic                       all_front;    // every plane so far saw a front corner
      logic                       none_behind;  // this corner is behind no plane so far
   } beat_type;

endpackage

@@ hdl/fcct_cell.sv @@
// One plane cell: holds a plane register and its per-box front flag, and
// passes each corner on to the next cell. Depends on fcct_pkg.
module fcct_cell import fcct_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  logic                plane_we,
   input  logic [PLANE_W-1:0]  plane_wdata,
   input  beat_type            beat_in,
   output beat_type            beat_out
);

   logic [PLANE_W-1:0]       plane_ff, plane_in;
   beat_type                 beat_ff;
   logic signed [PROD_W-1:0] prod_x_ff, prod_x_in;
   logic signed [PROD_W-1:0] prod_y_ff, prod_y_in;
   logic signed [PROD_W-1:0] prod_z_ff, prod_z_in;
   logic                     seen_ff, seen_in;
   logic signed [DIST_W-1:0] offset;
   logic signed [DIST_W-1:0] dist_sum;
   logic                     front;

   assign plane_in  = plane_we ? plane_wdata : plane_ff;

   assign prod_x_in = beat_in.x * $signed(plane_ff[15:0]);
   assign prod_y_in = beat_in.y * $signed(plane_ff[31:16]);
   assign prod_z_in = beat_in.z * $signed(plane_ff[47:32]);

   assign offset   = DIST_W'($signed(plane_ff[63:48])) <<< OFFSET_SHIFT;
   assign dist_sum = DIST_W'(prod_x_ff) + DIST_W'(prod_y_ff) + DIST_W'(prod_z_ff) + offset;
   assign front    = ~dist_sum[DIST_W-1];

   // The front flag belongs to the current box; the last corner closes it.
   always_comb begin
      seen_in = seen_ff;
      if (enable && beat_ff.valid) begin
         seen_in = beat_ff.last ? 1'b0 : (seen_ff | front);
      end
   end

   always_comb begin
      beat_out             = beat_ff;
      beat_out.all_front   = beat_ff.all_front & (seen_ff | front);
      beat_out.none_behind = beat_ff.none_behind & front;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff      <= '0;
         beat_ff.valid <= 1'b0;
         seen_ff       <= 1'b0;
      end else begin
         plane_ff <= plane_in;
         seen_ff  <= seen_in;
         if (enable) begin
            beat_ff <= beat_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
         prod_z_ff <= prod_z_in;
      end
   end

endmodule

@@ hdl/frustum_corner_cull_test_unit.sv @@
// Frustum corner cull test unit: a row of NUM_PLANES plane cells, one plane
// each, and the result register. Accepts one corner beat every cycle while the
// row is not halted; a box result enters the result register once its last
// corner has passed through every cell of the row.
// The row halts only while a finished result waits in the output register and
// another one reaches the end of the row. The user must write plane registers
// through the csr port only while no box is in flight; the block does not enforce it.
// Depends on fcct_pkg and fcct_cell.
module frustum_corner_cull_test_unit import fcct_pkg::*; #(
   parameter int NUM_PLANES = NUM_PLANES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [REQ_DATA_W-1:0]   req_tdata,   // corner_x, corner_y, corner_z
   input  logic                    req_tlast,   // last_corner
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RSP_DATA_W-1:0]   rsp_tdata,   // in_frustum, completely_inside, zeros
   input  logic                    csr_we,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [PLANE_W-1:0]      csr_wdata
);

   beat_type chain [NUM_PLANES+1];
   beat_type tail;
   logic     enable;
   logic     box_nb_ff, box_nb_in;
   logic     rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_data_ff, rsp_data_in;
   logic     tail_result;

   always_comb begin
      chain[0].valid       = req_tvalid;
      chain[0].last        = req_tlast;
      chain[0].x           = $signed(req_tdata[15:0]);
      chain[0].y           = $signed(req_tdata[31:16]);
      chain[0].z           = $signed(req_tdata[47:32]);
      chain[0].all_front   = 1'b1;
      chain[0].none_behind = 1'b1;
   end

   for (genvar p = 0; p < NUM_PLANES; p++) begin : g_cell
      logic we;
      if (p < NUM_PLANE_REGS) begin : g_reg
         assign we = csr_we && (csr_index == CSR_INDEX_W'(p));
      end else begin : g_fixed
         // No register backs this plane, so it stays zero and always counts as front.
         assign we = 1'b0;
      end
      fcct_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .enable      (enable),
         .plane_we    (we),
         .plane_wdata (csr_wdata),
         .beat_in     (chain[p]),
         .beat_out    (chain[p+1])
      );
   end

   assign tail        = chain[NUM_PLANES];
   assign tail_result = tail.valid && tail.last;
   assign enable      = !(tail_result && rsp_valid_ff && !rsp_tready);
   assign req_tready  = enable;

   always_comb begin
      box_nb_in = box_nb_ff;
      if (enable && tail.valid) begin
         box_nb_in = tail.last ? 1'b1 : (box_nb_ff & tail.none_behind);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (enable && tail_result) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {box_nb_ff & tail.none_behind, tail.all_front};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         box_nb_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         box_nb_ff    <= box_nb_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-2){1'b0}}, rsp_data_ff};

endmodule

@@ hdl/fcct_checker.sv @@
// Port-level checks for the frustum corner cull test unit, bound to the top.
// Depends on fcct_pkg and frustum_corner_cull_test_unit.
module fcct_checker import fcct_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // A stalled result beat keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // A box with no corner behind any plane must be in the frustum.
   a_inside_implies_in: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] |-> rsp_tdata[0])
      else $error("completely inside without in frustum");

   // Reset empties the result register.
   a_reset_rsp: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // With the row empty after reset, the input side is open.
   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("input not ready after reset");

endmodule

bind frustum_corner_cull_test_unit fcct_checker u_fcct_checker (.*);
